// File: rtl/cpcr_pkg.sv
// Shared types, constants and rounding and saturation helpers for the circle pair collision resolver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpcr_pkg;

    localparam int FIELD_W     = 24;
    localparam int SQRT_STAGES = 18;   // one root bit per stage
    localparam int DIV_STAGES  = 17;   // one quotient bit per stage
    localparam int D2_W        = 35;
    localparam int DIST_W      = 18;
    localparam int NUM_W       = 34;
    localparam int QUO_W       = 17;
    localparam int MAG_W       = 17;

    localparam logic [15:0] RADIUS_RESET      = 16'd4224;
    localparam logic [8:0]  RESTITUTION_RESET = 9'd205;

    typedef enum logic [0:0] {
        REG_BALL_RADIUS = 1'b0,
        REG_RESTITUTION = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] first_x;
        logic signed [FIELD_W-1:0] first_y;
        logic signed [FIELD_W-1:0] first_vx;
        logic signed [FIELD_W-1:0] first_vy;
        logic signed [FIELD_W-1:0] second_x;
        logic signed [FIELD_W-1:0] second_y;
        logic signed [FIELD_W-1:0] second_vx;
        logic signed [FIELD_W-1:0] second_vy;
    } pair_t;

    typedef struct packed {
        logic                      hit;
        logic signed [FIELD_W-1:0] new_first_x;
        logic signed [FIELD_W-1:0] new_first_y;
        logic signed [FIELD_W-1:0] new_first_vx;
        logic signed [FIELD_W-1:0] new_first_vy;
        logic signed [FIELD_W-1:0] new_second_x;
        logic signed [FIELD_W-1:0] new_second_y;
        logic signed [FIELD_W-1:0] new_second_vx;
        logic signed [FIELD_W-1:0] new_second_vy;
    } result_t;

    // Per-item context carried alongside the root and divide pipelines.
    typedef struct packed {
        pair_t             item;
        logic              hit;
        logic              sx;
        logic              sy;
        logic [MAG_W-1:0]  mx;
        logic [MAG_W-1:0]  my;
        logic [DIST_W-1:0] root_dist;
    } ctx_t;

    // Arithmetic shift right, round to nearest, ties away from zero.
    function automatic logic signed [63:0] shr_rnd(input logic signed [63:0] v,
                                                   input int unsigned sh);
        logic signed [63:0] h;
        logic signed [63:0] adj;
        h   = 64'sd1 <<< (sh - 1);
        adj = v[63] ? (h - 64'sd1) : h;
        return (v + adj) >>> sh;
    endfunction

    function automatic logic signed [FIELD_W-1:0] sat24(input logic signed [63:0] v);
        logic signed [FIELD_W-1:0] r;
        if (v > 64'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -64'sd8388608)
            r = 24'sh800000;
        else
            r = v[FIELD_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/cpcr_sqrt.sv
// Pipelined integer square root, one result bit per stage, floor(sqrt(d2)).
// Depends on cpcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpcr_sqrt (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic [cpcr_pkg::D2_W-1:0]        d2,
    output logic      [cpcr_pkg::DIST_W-1:0]      root
);

    localparam int RW = cpcr_pkg::D2_W + 1;

    logic [RW-1:0]                  rem_reg  [cpcr_pkg::SQRT_STAGES];
    logic [cpcr_pkg::DIST_W-1:0]    root_reg [cpcr_pkg::SQRT_STAGES];

    for (genvar k = 0; k < cpcr_pkg::SQRT_STAGES; k++) begin : g_stage
        localparam int I = cpcr_pkg::SQRT_STAGES - 1 - k;
        logic [RW-1:0]               rem_in;
        logic [cpcr_pkg::DIST_W-1:0] root_in;
        logic [RW-1:0]               inc;
        logic [RW-1:0]               rem_next;
        logic [cpcr_pkg::DIST_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign rem_in  = RW'(d2);
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // (2*root + 2^I) * 2^I
        assign inc = (RW'(root_in) << (I + 1)) + (RW'(1) << (2 * I));

        always_comb
        begin
            if (rem_in >= inc)
            begin
                rem_next  = rem_in - inc;
                root_next = root_in | (cpcr_pkg::DIST_W'(1) << I);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign root = root_reg[cpcr_pkg::SQRT_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/cpcr_div.sv
// Pipelined restoring divider, one quotient bit per stage (quotient below 2^17).
// Depends on cpcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpcr_div (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [cpcr_pkg::NUM_W-1:0]    num,
    input  wire logic [cpcr_pkg::DIST_W-1:0]   den,
    output logic      [cpcr_pkg::QUO_W-1:0]    quo
);

    localparam int RW = cpcr_pkg::NUM_W + 1;

    logic [RW-1:0]                rem_reg [cpcr_pkg::DIV_STAGES];
    logic [cpcr_pkg::DIST_W-1:0]  den_reg [cpcr_pkg::DIV_STAGES];
    logic [cpcr_pkg::QUO_W-1:0]   quo_reg [cpcr_pkg::DIV_STAGES];

    for (genvar k = 0; k < cpcr_pkg::DIV_STAGES; k++) begin : g_stage
        localparam int I = cpcr_pkg::DIV_STAGES - 1 - k;
        logic [RW-1:0]               rem_in;
        logic [cpcr_pkg::DIST_W-1:0] den_in;
        logic [cpcr_pkg::QUO_W-1:0]  quo_in;
        logic [RW-1:0]               sub;
        logic [RW-1:0]               rem_next;
        logic [cpcr_pkg::QUO_W-1:0]  quo_next;

        if (k == 0) begin : g_first
            assign rem_in = RW'(num);
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign sub = RW'(den_in) << I;

        always_comb
        begin
            if (rem_in >= sub)
            begin
                rem_next = rem_in - sub;
                quo_next = quo_in | (cpcr_pkg::QUO_W'(1) << I);
            end
            else
            begin
                rem_next = rem_in;
                quo_next = quo_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[cpcr_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// File: rtl/circle_pair_collision_resolve.sv
// Top level of the circle pair collision resolver: overlap test, normal, push and impulse.
// Depends on cpcr_pkg, cpcr_sqrt and cpcr_div.
`timescale 1ns / 1ps
`default_nettype none

// Resolves one pair of equal circles per beat. Fully pipelined: a new pair is taken
// every clock while the result side keeps up, and each pair passes through 3 setup
// stages, 18 square-root stages, 17 divide stages and 8 impulse stages. The whole
// pipe advances on one enable, so a stall on the result side holds every stage and
// backs up to pair_stall only while the output register is full and stalled; no beat
// is dropped or repeated. Registers ball_radius and restitution are read live by the
// stages, so write them only while the pipe is empty.
module circle_pair_collision_resolve (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pair_valid,
    output logic                      pair_stall,
    input  wire cpcr_pkg::pair_t      pair,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output cpcr_pkg::result_t         res,
    input  wire logic                 cfg_we,
    input  wire cpcr_pkg::cfg_reg_t   cfg_index,
    input  wire logic [15:0]          cfg_data
);

    localparam int NS = cpcr_pkg::SQRT_STAGES;
    localparam int ND = cpcr_pkg::DIV_STAGES;

    // ---- configuration ----
    logic [15:0] radius_reg;
    logic [8:0]  rest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= cpcr_pkg::RADIUS_RESET;
            rest_reg   <= cpcr_pkg::RESTITUTION_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cpcr_pkg::REG_BALL_RADIUS: radius_reg <= cfg_data;
                cpcr_pkg::REG_RESTITUTION: rest_reg   <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    logic [16:0] two_r;
    assign two_r = {radius_reg, 1'b0};

    // Global advance: move unless the output holds a beat nobody took.
    logic en;
    assign en         = !res_valid || !res_stall;
    assign pair_stall = !en;

    // ---- stage A: center differences ----
    logic                 a_valid_reg;
    cpcr_pkg::pair_t      a_item_reg;
    logic signed [24:0]   a_dx_reg, a_dy_reg;

    // ---- stage B: magnitudes, squares, limit ----
    logic                 b_valid_reg;
    cpcr_pkg::pair_t      b_item_reg;
    logic                 b_near_reg, b_sx_reg, b_sy_reg;
    logic [16:0]          b_mx_reg, b_my_reg;
    logic [33:0]          b_sqx_reg, b_sqy_reg, b_lim_reg;

    // ---- stage C: distance squared and overlap test ----
    logic                 c_valid_reg;
    cpcr_pkg::ctx_t       c_ctx_reg;
    logic [cpcr_pkg::D2_W-1:0] c_d2_reg;

    logic [24:0] adx, ady;
    logic [cpcr_pkg::D2_W-1:0] d2_sum;
    assign adx    = a_dx_reg[24] ? 25'(-a_dx_reg) : 25'(a_dx_reg);
    assign ady    = a_dy_reg[24] ? 25'(-a_dy_reg) : 25'(a_dy_reg);
    assign d2_sum = cpcr_pkg::D2_W'(b_sqx_reg) + cpcr_pkg::D2_W'(b_sqy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= pair_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg <= pair;
            a_dx_reg   <= 25'(pair.second_x) - 25'(pair.first_x);
            a_dy_reg   <= 25'(pair.second_y) - 25'(pair.first_y);

            b_item_reg <= a_item_reg;
            // beyond 2^17 on either axis the pair can never overlap
            b_near_reg <= (adx[24:17] == '0) && (ady[24:17] == '0);
            b_sx_reg   <= a_dx_reg[24];
            b_sy_reg   <= a_dy_reg[24];
            b_mx_reg   <= adx[16:0];
            b_my_reg   <= ady[16:0];
            b_sqx_reg  <= 34'(adx[16:0]) * 34'(adx[16:0]);
            b_sqy_reg  <= 34'(ady[16:0]) * 34'(ady[16:0]);
            b_lim_reg  <= 34'(two_r) * 34'(two_r);

            c_d2_reg            <= d2_sum;
            c_ctx_reg.item      <= b_item_reg;
            c_ctx_reg.hit       <= b_near_reg && (d2_sum != '0) &&
                                   (d2_sum < cpcr_pkg::D2_W'(b_lim_reg));
            c_ctx_reg.sx        <= b_sx_reg;
            c_ctx_reg.sy        <= b_sy_reg;
            c_ctx_reg.mx        <= b_mx_reg;
            c_ctx_reg.my        <= b_my_reg;
            c_ctx_reg.root_dist <= '0;
        end
    end

    // ---- square root and its context line ----
    logic [cpcr_pkg::DIST_W-1:0] root;
    cpcr_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .d2   (c_d2_reg),
        .root (root)
    );

    logic           s_valid_reg [NS];
    cpcr_pkg::ctx_t s_ctx_reg   [NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
                s_valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            s_valid_reg[0] <= c_valid_reg;
            for (int k = 1; k < NS; k++)
                s_valid_reg[k] <= s_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_ctx_reg[0] <= c_ctx_reg;
            for (int k = 1; k < NS; k++)
                s_ctx_reg[k] <= s_ctx_reg[k-1];
        end
    end

    // ---- normal components: round(m * 2^16 / dist) ----
    cpcr_pkg::ctx_t root_ctx;
    logic [cpcr_pkg::NUM_W-1:0] num_x, num_y;
    always_comb
    begin
        root_ctx           = s_ctx_reg[NS-1];
        root_ctx.root_dist = root;
    end
    assign num_x = {root_ctx.mx, 16'd0} + cpcr_pkg::NUM_W'(root >> 1);
    assign num_y = {root_ctx.my, 16'd0} + cpcr_pkg::NUM_W'(root >> 1);

    logic [cpcr_pkg::QUO_W-1:0] qx, qy;
    cpcr_div u_div_x (.clk(clk), .en(en), .num(num_x), .den(root), .quo(qx));
    cpcr_div u_div_y (.clk(clk), .en(en), .num(num_y), .den(root), .quo(qy));

    logic           v_valid_reg [ND];
    cpcr_pkg::ctx_t v_ctx_reg   [ND];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ND; k++)
                v_valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_valid_reg[0] <= s_valid_reg[NS-1];
            for (int k = 1; k < ND; k++)
                v_valid_reg[k] <= v_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_ctx_reg[0] <= root_ctx;
            for (int k = 1; k < ND; k++)
                v_ctx_reg[k] <= v_ctx_reg[k-1];
        end
    end

    cpcr_pkg::ctx_t dctx;
    assign dctx = v_ctx_reg[ND-1];

    // ---- impulse stages D..K ----
    logic d_valid_reg, e_valid_reg, f_valid_reg, g_valid_reg;
    logic h_valid_reg, i_valid_reg, j_valid_reg, k_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
            j_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= v_valid_reg[ND-1];
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
            i_valid_reg <= h_valid_reg;
            j_valid_reg <= i_valid_reg;
            k_valid_reg <= j_valid_reg;
        end
    end

    // D: signed normal, overlap depth, relative velocity
    cpcr_pkg::pair_t    d_item_reg;
    logic               d_hit_reg;
    logic signed [17:0] d_nx_reg, d_ny_reg;
    logic signed [18:0] d_ovl_reg;
    logic signed [24:0] d_rvx_reg, d_rvy_reg;
    // E: products
    cpcr_pkg::pair_t    e_item_reg;
    logic               e_hit_reg;
    logic signed [17:0] e_nx_reg, e_ny_reg;
    logic signed [36:0] e_pxp_reg, e_pyp_reg;
    logic signed [42:0] e_dotx_reg, e_doty_reg;
    // F: push vector, dot sum
    cpcr_pkg::pair_t    f_item_reg;
    logic               f_hit_reg;
    logic signed [17:0] f_nx_reg, f_ny_reg;
    logic signed [19:0] f_px_reg, f_py_reg;
    logic signed [43:0] f_dot_reg;
    // G: pushed centers, normal velocity
    cpcr_pkg::pair_t    g_item_reg;
    logic               g_hit_reg;
    logic signed [17:0] g_nx_reg, g_ny_reg;
    logic signed [25:0] g_x1_reg, g_y1_reg, g_x2_reg, g_y2_reg;
    logic signed [27:0] g_vn_reg;
    // H: impulse magnitude product
    cpcr_pkg::pair_t    h_item_reg;
    logic               h_hit_reg, h_bounce_reg;
    logic signed [17:0] h_nx_reg, h_ny_reg;
    logic signed [25:0] h_x1_reg, h_y1_reg, h_x2_reg, h_y2_reg;
    logic signed [39:0] h_jp_reg;
    // I: impulse magnitude
    cpcr_pkg::pair_t    i_item_reg;
    logic               i_bounce_reg;
    logic signed [17:0] i_nx_reg, i_ny_reg;
    logic signed [25:0] i_x1_reg, i_y1_reg, i_x2_reg, i_y2_reg;
    logic signed [30:0] i_j_reg;
    // J: impulse vector products
    cpcr_pkg::pair_t    j_item_reg;
    logic               j_hit_reg, j_bounce_reg;
    logic signed [25:0] j_x1_reg, j_y1_reg, j_x2_reg, j_y2_reg;
    logic signed [48:0] j_ixp_reg, j_iyp_reg;
    logic               i_hit_reg;
    // K: output register
    cpcr_pkg::result_t  k_res_reg;

    logic signed [31:0] ix, iy;
    logic signed [32:0] vx1n, vy1n, vx2n, vy2n;
    assign ix = 32'(cpcr_pkg::shr_rnd(64'(j_ixp_reg), 16));
    assign iy = 32'(cpcr_pkg::shr_rnd(64'(j_iyp_reg), 16));

    always_comb
    begin
        vx1n = 33'(j_item_reg.first_vx);
        vy1n = 33'(j_item_reg.first_vy);
        vx2n = 33'(j_item_reg.second_vx);
        vy2n = 33'(j_item_reg.second_vy);
        if (j_hit_reg && j_bounce_reg)
        begin
            vx1n = vx1n - 33'(ix);
            vy1n = vy1n - 33'(iy);
            vx2n = vx2n + 33'(ix);
            vy2n = vy2n + 33'(iy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_item_reg <= dctx.item;
            d_hit_reg  <= dctx.hit;
            d_nx_reg   <= dctx.sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            d_ny_reg   <= dctx.sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
            d_ovl_reg  <= $signed({2'b00, two_r}) - $signed({1'b0, dctx.root_dist});
            d_rvx_reg  <= 25'(dctx.item.second_vx) - 25'(dctx.item.first_vx);
            d_rvy_reg  <= 25'(dctx.item.second_vy) - 25'(dctx.item.first_vy);

            e_item_reg <= d_item_reg;
            e_hit_reg  <= d_hit_reg;
            e_nx_reg   <= d_nx_reg;
            e_ny_reg   <= d_ny_reg;
            e_pxp_reg  <= 37'(d_nx_reg) * 37'(d_ovl_reg);
            e_pyp_reg  <= 37'(d_ny_reg) * 37'(d_ovl_reg);
            e_dotx_reg <= 43'(d_rvx_reg) * 43'(d_nx_reg);
            e_doty_reg <= 43'(d_rvy_reg) * 43'(d_ny_reg);

            f_item_reg <= e_item_reg;
            f_hit_reg  <= e_hit_reg;
            f_nx_reg   <= e_nx_reg;
            f_ny_reg   <= e_ny_reg;
            f_px_reg   <= 20'(cpcr_pkg::shr_rnd(64'(e_pxp_reg), 17));
            f_py_reg   <= 20'(cpcr_pkg::shr_rnd(64'(e_pyp_reg), 17));
            f_dot_reg  <= 44'(e_dotx_reg) + 44'(e_doty_reg);

            g_item_reg <= f_item_reg;
            g_hit_reg  <= f_hit_reg;
            g_nx_reg   <= f_nx_reg;
            g_ny_reg   <= f_ny_reg;
            if (f_hit_reg)
            begin
                g_x1_reg <= 26'(f_item_reg.first_x)  - 26'(f_px_reg);
                g_y1_reg <= 26'(f_item_reg.first_y)  - 26'(f_py_reg);
                g_x2_reg <= 26'(f_item_reg.second_x) + 26'(f_px_reg);
                g_y2_reg <= 26'(f_item_reg.second_y) + 26'(f_py_reg);
            end
            else
            begin
                g_x1_reg <= 26'(f_item_reg.first_x);
                g_y1_reg <= 26'(f_item_reg.first_y);
                g_x2_reg <= 26'(f_item_reg.second_x);
                g_y2_reg <= 26'(f_item_reg.second_y);
            end
            g_vn_reg   <= 28'(cpcr_pkg::shr_rnd(64'(f_dot_reg), 16));

            h_item_reg   <= g_item_reg;
            h_hit_reg    <= g_hit_reg;
            h_bounce_reg <= (g_vn_reg <= 28'sd0);   // approaching or resting
            h_nx_reg     <= g_nx_reg;
            h_ny_reg     <= g_ny_reg;
            h_x1_reg     <= g_x1_reg;
            h_y1_reg     <= g_y1_reg;
            h_x2_reg     <= g_x2_reg;
            h_y2_reg     <= g_y2_reg;
            h_jp_reg     <= (-40'(g_vn_reg)) *
                            $signed({30'd0, 10'(10'd256 + 10'(rest_reg))});

            i_item_reg   <= h_item_reg;
            i_hit_reg    <= h_hit_reg;
            i_bounce_reg <= h_bounce_reg;
            i_nx_reg     <= h_nx_reg;
            i_ny_reg     <= h_ny_reg;
            i_x1_reg     <= h_x1_reg;
            i_y1_reg     <= h_y1_reg;
            i_x2_reg     <= h_x2_reg;
            i_y2_reg     <= h_y2_reg;
            i_j_reg      <= 31'(cpcr_pkg::shr_rnd(64'(h_jp_reg), 9));

            j_item_reg   <= i_item_reg;
            j_hit_reg    <= i_hit_reg;
            j_bounce_reg <= i_bounce_reg;
            j_x1_reg     <= i_x1_reg;
            j_y1_reg     <= i_y1_reg;
            j_x2_reg     <= i_x2_reg;
            j_y2_reg     <= i_y2_reg;
            j_ixp_reg    <= 49'(i_j_reg) * 49'(i_nx_reg);
            j_iyp_reg    <= 49'(i_j_reg) * 49'(i_ny_reg);

            k_res_reg.hit           <= j_hit_reg;
            k_res_reg.new_first_x   <= cpcr_pkg::sat24(64'(j_x1_reg));
            k_res_reg.new_first_y   <= cpcr_pkg::sat24(64'(j_y1_reg));
            k_res_reg.new_second_x  <= cpcr_pkg::sat24(64'(j_x2_reg));
            k_res_reg.new_second_y  <= cpcr_pkg::sat24(64'(j_y2_reg));
            k_res_reg.new_first_vx  <= cpcr_pkg::sat24(64'(vx1n));
            k_res_reg.new_first_vy  <= cpcr_pkg::sat24(64'(vy1n));
            k_res_reg.new_second_vx <= cpcr_pkg::sat24(64'(vx2n));
            k_res_reg.new_second_vy <= cpcr_pkg::sat24(64'(vy2n));
        end
    end

    assign res_valid = k_valid_reg;
    assign res       = k_res_reg;

endmodule

`default_nettype wire

// File: rtl/cpcr_checker.sv
// Port-level checks for circle_pair_collision_resolve, bound to the top level.
// Depends on cpcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpcr_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              pair_valid,
    input wire logic              pair_stall,
    input wire logic              res_valid,
    input wire logic              res_stall,
    input wire cpcr_pkg::result_t res
);

    // input side backs up only behind a blocked result beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pair_stall |-> (res_valid && res_stall))
        else $error("pair_stall without a blocked result");

    // a blocked result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res)))
        else $error("result beat changed while stalled");

    // an empty output never blocks input
    a_empty_flows: assert property (@(posedge clk) disable iff (!rst_n)
        (!res_valid && pair_valid) |-> !pair_stall)
        else $error("input stalled with empty output");

endmodule

bind circle_pair_collision_resolve cpcr_checker u_cpcr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
);

`default_nettype wire

// File: dv/cpcr_checker.sv
// Checker for the circle pair collision resolver: predicts each result and compares it.
// Depends on cpcr_pkg for the beat structs and register indexes.
`timescale 1ns / 1ps

module cpcr_scoreboard (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pair_valid,
    input  wire logic               pair_stall,
    input  wire cpcr_pkg::pair_t    pair,
    input  wire logic               res_valid,
    input  wire logic               res_stall,
    input  wire cpcr_pkg::result_t  res,
    input  wire logic               cfg_we,
    input  wire cpcr_pkg::cfg_reg_t cfg_index,
    input  wire logic [15:0]        cfg_data,
    output int                      errors,
    output int                      pending
);
    import cpcr_pkg::*;

    logic [15:0] radius_q;
    logic [8:0]  bounce_q;
    result_t     resolved_q[$];

    function automatic longint round_shift(longint v, int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unit_part(longint d, longint dlen);
        longint m;
        longint q;
        m = (d < 0) ? -d : d;
        q = ((m <<< 16) + dlen / 2) / dlen;
        return (d < 0) ? -q : q;
    endfunction

    function automatic logic signed [23:0] clamp24(longint v);
        if (v > 8388607)
            return 24'sh7FFFFF;
        if (v < -8388608)
            return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic result_t resolve_pair(pair_t p, logic [15:0] rad, logic [8:0] bnc);
        longint  x1, y1, vx1, vy1, x2, y2, vx2, vy2;
        longint  dx, dy, d2, two_r, dlen, nx, ny, ovl, px, py, vn, j, ix, iy;
        result_t r;
        x1 = p.first_x;   y1 = p.first_y;   vx1 = p.first_vx;  vy1 = p.first_vy;
        x2 = p.second_x;  y2 = p.second_y;  vx2 = p.second_vx; vy2 = p.second_vy;
        dx = x2 - x1;
        dy = y2 - y1;
        d2 = dx * dx + dy * dy;
        two_r = 2 * longint'(rad);
        r.hit = 1'b0;
        if (d2 != 0 && d2 < two_r * two_r)
        begin
            dlen = int_sqrt(d2);
            nx = unit_part(dx, dlen);
            ny = unit_part(dy, dlen);
            ovl = two_r - dlen;
            px = round_shift(nx * ovl, 17);
            py = round_shift(ny * ovl, 17);
            r.hit = 1'b1;
            x1 -= px; y1 -= py;
            x2 += px; y2 += py;
            vn = round_shift((vx2 - vx1) * nx + (vy2 - vy1) * ny, 16);
            // only an approaching pair gets the impulse
            if (vn <= 0)
            begin
                j = round_shift(-vn * (256 + longint'(bnc)), 9);
                ix = round_shift(j * nx, 16);
                iy = round_shift(j * ny, 16);
                vx1 -= ix; vy1 -= iy;
                vx2 += ix; vy2 += iy;
            end
        end
        r.new_first_x   = clamp24(x1);
        r.new_first_y   = clamp24(y1);
        r.new_first_vx  = clamp24(vx1);
        r.new_first_vy  = clamp24(vy1);
        r.new_second_x  = clamp24(x2);
        r.new_second_y  = clamp24(y2);
        r.new_second_vx = clamp24(vx2);
        r.new_second_vy = clamp24(vy2);
        return r;
    endfunction

    function automatic void check_field(string name, logic [23:0] e, logic [23:0] a);
        if (e !== a)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected %0d got %0d", name,
                         $signed(e), $signed(a));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            radius_q = RADIUS_RESET;
            bounce_q = RESTITUTION_RESET;
            resolved_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_BALL_RADIUS)
                    radius_q = cfg_data;
                else
                    bounce_q = cfg_data[8:0];
            end
            if (pair_valid && !pair_stall)
                resolved_q = {resolved_q, resolve_pair(pair, radius_q, bounce_q)};
            if (res_valid && !res_stall)
            begin
                if (resolved_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat");
                end
                else
                begin
                    e = resolved_q.pop_front();
                    check_field("hit", 24'(e.hit), 24'(res.hit));
                    check_field("new_first_x", e.new_first_x, res.new_first_x);
                    check_field("new_first_y", e.new_first_y, res.new_first_y);
                    check_field("new_first_vx", e.new_first_vx, res.new_first_vx);
                    check_field("new_first_vy", e.new_first_vy, res.new_first_vy);
                    check_field("new_second_x", e.new_second_x, res.new_second_x);
                    check_field("new_second_y", e.new_second_y, res.new_second_y);
                    check_field("new_second_vx", e.new_second_vx, res.new_second_vx);
                    check_field("new_second_vy", e.new_second_vy, res.new_second_vy);
                end
            end
            pending = resolved_q.size();
        end
    end

endmodule

// File: dv/tb_circle_pair_collision_resolve.sv
// Testbench top for the circle pair collision resolver: clock, reset, stimulus, verdict.
// Depends on cpcr_pkg, the resolver RTL and cpcr_scoreboard.
`timescale 1ns / 1ps

module tb_circle_pair_collision_resolve;
    import cpcr_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      pair_valid;
    logic      pair_stall;
    pair_t     pair;
    logic      res_valid;
    logic      res_stall;
    result_t   res;
    logic      cfg_we;
    cfg_reg_t  cfg_index;
    logic [15:0] cfg_data;
    int        errors;
    int        pending;

    // idling knobs, percent per cycle
    int        idle_pct;
    int        stall_pct;
    int        hold_left;   // receiver hold-off, counted down by the stall process
    int        cycles;
    logic [15:0] cur_radius;

    circle_pair_collision_resolve i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair       (pair),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    cpcr_scoreboard i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_stall (pair_stall),
        .pair       (pair),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .errors     (errors),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Receiver side: a long hold-off when asked, else random stalls.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else
            res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Run limit, far above the slowest correct run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 600000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic pair_t mk(int x1, int y1, int vx1, int vy1,
                                 int x2, int y2, int vx2, int vy2);
        pair_t p;
        p.first_x  = 24'(x1); p.first_y  = 24'(y1);
        p.first_vx = 24'(vx1); p.first_vy = 24'(vy1);
        p.second_x  = 24'(x2); p.second_y  = 24'(y2);
        p.second_vx = 24'(vx2); p.second_vy = 24'(vy2);
        return p;
    endfunction

    // Mostly pairs near contact for the current radius, some raw noise.
    function automatic pair_t rand_pair(logic [15:0] rad);
        pair_t p;
        int    span;
        int    x1, y1;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 99) < 80)
        begin
            span = 2 * rad + 512;
            x1 = $urandom_range(0, 99) < 10 ? int'($signed(p.first_x))
                                            : $urandom_range(0, 8000000) - 4000000;
            y1 = $urandom_range(0, 8000000) - 4000000;
            p.first_x  = 24'(x1);
            p.first_y  = 24'(y1);
            p.second_x = 24'(x1 + $urandom_range(0, 2 * span) - span);
            p.second_y = 24'(y1 + $urandom_range(0, 2 * span) - span);
            if ($urandom_range(0, 99) < 85)
            begin
                p.first_vx  = 24'($urandom_range(0, 16383) - 8192);
                p.first_vy  = 24'($urandom_range(0, 16383) - 8192);
                p.second_vx = 24'($urandom_range(0, 16383) - 8192);
                p.second_vy = 24'($urandom_range(0, 16383) - 8192);
            end
        end
        return p;
    endfunction

    // One beat toward the block; idle cycles land before it at random.
    task automatic send_pair(pair_t p);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            pair_valid <= 1'b0;
            @(negedge clk);
        end
        pair_valid <= 1'b1;
        pair       <= p;
        do
            @(posedge clk);
        while (pair_stall);
    endtask

    task automatic drain();
        @(negedge clk);
        pair_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        // pipe is 46 deep; let it empty fully before touching registers
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        if (idx == REG_BALL_RADIUS)
            cur_radius = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int radii [6] = '{16'd4224, 16'd0, 16'd65535, 16'd300, 16'd1, 16'd4224};
        int bounce[6] = '{9'd205, 9'd256, 9'd0, 9'd511, 9'd128, 9'd205};
        pair_valid = 1'b0;
        pair       = '0;
        res_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_BALL_RADIUS;
        cfg_data   = '0;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_left  = 0;
        cycles     = 0;
        cur_radius = RADIUS_RESET;
        rst_n      = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats at reset settings (contact distance 8448).
        send_pair(mk(0, 0, 100, 100, 0, 0, -100, -100));              // coincident
        send_pair(mk(0, 0, 256, 0, 100000, 0, -256, 0));              // far apart
        send_pair(mk(0, 0, 256, 0, 8448, 0, -256, 0));                // just touching
        send_pair(mk(0, 0, 256, 0, 8447, 0, -256, 0));                // barely overlapped
        send_pair(mk(0, 0, -256, 0, 1000, 0, 256, 0));                // separating
        send_pair(mk(500, 500, 300, -200, 3500, -3500, -100, 400));   // diagonal
        send_pair(mk(0, 0, 0, 0, -2000, 1, 0, 0));                    // negative dx, at rest
        send_pair(mk(-8388608, 0, 8388607, 0, -8388508, 0, -8388608, 0));
        send_pair(mk(8388600, 8388600, 0, 0, 8388607, 8388607, -512, -512));
        send_pair(mk(-8388608, -8388608, -8388608, -8388608,
                     -8388608, -8388608, -8388608, -8388608));
        send_pair(mk(8388607, 8388607, 8388607, 8388607,
                     8388607, 8388607, 8388607, 8388607));
        send_pair(mk(-8388608, 0, 0, 0, 8388607, 0, 0, 0));          // widest gap
        send_pair(mk(0, 0, 0, 8388607, 0, 10, 0, -8388608));         // huge impulse, vertical
        send_pair(mk(0, 0, 0, 0, 1, 0, 0, 0));                       // deepest overlap
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_BALL_RADIUS, 16'(radii[ph]));
            write_reg(REG_RESTITUTION, 16'(bounce[ph]));
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 78; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 78; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            // pressure: receiver holds off long while the sender keeps offering
            if (ph == 3)
            begin
                idle_pct  = 0;
                hold_left = 400;
            end
            for (int n = 0; n < 200; n++)
            begin
                if (ph == 3 && n == 150)
                    idle_pct = 14;
                // occasional calm stretch with no idling
                if (n == 120 && ph != 3)
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                send_pair(rand_pair(cur_radius));
                // sender pauses until every result is back
                if (ph == 1 && n == 60)
                    drain();
            end
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
rtl/cpcr_pkg.sv
rtl/cpcr_sqrt.sv
rtl/cpcr_div.sv
rtl/circle_pair_collision_resolve.sv
rtl/cpcr_checker.sv
dv/cpcr_checker.sv
dv/tb_circle_pair_collision_resolve.sv
